/* sv/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/swe_pkg.sv */
// Shared constants and control types for the stereo waveform envelope block.
// Depends on nothing; imported by the controller, datapath and top level.
package swe_pkg;

    // Longest chunk that is summed, and the widths that follow from it.
    localparam int MAX_CHUNK_FRAMES = 65536;
    localparam int SAMPLE_W         = 16;
    localparam int CNT_W            = $clog2(MAX_CHUNK_FRAMES + 1);
    localparam int ACC_W            = SAMPLE_W + CNT_W;
    localparam int STEP_W           = 16;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS        = ACC_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 1'b1;

    // Sample format codes.
    localparam logic FMT_U8  = 1'b0;
    localparam logic FMT_S16 = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // an input item is taken this cycle
        logic chunk_close; // the item taken ends its chunk
        logic div_step;    // advance both divider lanes by one bit
        logic load_out;    // write the result item into the output register
    } t_swe_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;    // the divider is on its final bit
    } t_swe_sts;

endpackage

/* sv/swe_ctrl.sv */
// Controller for the stereo waveform envelope block: handshakes and sequencing.
// Depends on swe_pkg for the command and status types.
module swe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_chunk_end,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  swe_pkg::t_swe_sts i_sts,
    output swe_pkg::t_swe_cmd o_cmd
);
    import swe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    // Items are taken only while idle; the output slot is free when empty or draining.
    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands.
    always_comb begin
        n_state           = r_state;
        o_cmd.accept      = accept;
        o_cmd.chunk_close = accept && i_chunk_end;
        o_cmd.div_step    = 1'b0;
        o_cmd.load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_chunk_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid is set on a load and held while the receiver stalls.
    always_comb begin
        n_out_valid = o_cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/swe_dp.sv */
// Datapath for the stereo waveform envelope block: normalization, accumulation,
// a two-lane serial divider, running extremes and the output register. Uses swe_pkg.
module swe_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [swe_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [swe_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [15:0]                            i_left_raw,
    input  logic [15:0]                            i_right_raw,
    input  logic                                   i_new_file,
    input  swe_pkg::t_swe_cmd                      i_cmd,
    output swe_pkg::t_swe_sts                      o_sts,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_mean_left,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_mean_right,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_max_left,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_max_right,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_min_left,
    output logic signed [swe_pkg::SAMPLE_W-1:0]    o_min_right,
    output logic [swe_pkg::CNT_W-1:0]              o_frames_used
);
    import swe_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] PEAK_RESET   = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] TROUGH_RESET = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [ACC_W-1:0] quo;
    } t_lane;

    // An 8-bit unsigned sample scaled to Q1.15. With a = |v-128| <= 128,
    // a*32768/255 = a*128 + a*128/255, and the last term floors to a/2.
    function automatic logic signed [SAMPLE_W-1:0] f_norm8(input logic [7:0] raw);
        logic signed [8:0] c;
        logic [7:0]        a;
        logic [15:0]       q;
        c = $signed({1'b0, raw}) - 9'sd128;
        a = c[8] ? 8'(-c) : 8'(c);
        q = {1'b0, a, 7'd0} + {9'd0, a[7:1]};
        return c[8] ? $signed(-q) : $signed(q);
    endfunction

    // One restoring division step: shift in the next dividend bit and try a subtract.
    function automatic t_lane f_div_step(input t_lane cur, input logic [CNT_W-1:0] den);
        logic [CNT_W:0]   rem_sh;
        logic [CNT_W+1:0] diff;
        t_lane            nxt;
        rem_sh = {cur.rem, cur.quo[ACC_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den};
        if (!diff[CNT_W+1]) begin
            nxt.rem = diff[CNT_W-1:0];
            nxt.quo = {cur.quo[ACC_W-2:0], 1'b1};
        end else begin
            nxt.rem = rem_sh[CNT_W-1:0];
            nxt.quo = {cur.quo[ACC_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Configuration registers.
    logic                  r_sample_format;
    logic [STEP_W-1:0]     r_step_cfg;

    // Chunk state.
    logic [STEP_W-1:0]     r_phase;
    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_r;
    logic [CNT_W-1:0]      r_count;
    logic signed [SAMPLE_W-1:0] r_peak_l;
    logic signed [SAMPLE_W-1:0] r_peak_r;
    logic signed [SAMPLE_W-1:0] r_trough_l;
    logic signed [SAMPLE_W-1:0] r_trough_r;

    // Divider.
    t_lane                 r_lane_l;
    t_lane                 r_lane_r;
    logic                  r_neg_l;
    logic                  r_neg_r;
    logic [CNT_W-1:0]      r_den;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    // Output register.
    logic signed [SAMPLE_W-1:0] r_out_mean_l;
    logic signed [SAMPLE_W-1:0] r_out_mean_r;
    logic signed [SAMPLE_W-1:0] r_out_max_l;
    logic signed [SAMPLE_W-1:0] r_out_max_r;
    logic signed [SAMPLE_W-1:0] r_out_min_l;
    logic signed [SAMPLE_W-1:0] r_out_min_r;
    logic [CNT_W-1:0]      r_out_frames;

    logic [STEP_W-1:0]     step_eff;
    logic [STEP_W-1:0]     phase_a;
    logic [STEP_W:0]       phase_inc;
    logic [STEP_W-1:0]     n_phase;
    logic                  take;
    logic signed [SAMPLE_W-1:0] smp_l;
    logic signed [SAMPLE_W-1:0] smp_r;
    logic signed [ACC_W-1:0] n_acc_l;
    logic signed [ACC_W-1:0] n_acc_r;
    logic [CNT_W-1:0]      n_count;
    logic signed [SAMPLE_W-1:0] peak_base_l;
    logic signed [SAMPLE_W-1:0] peak_base_r;
    logic signed [SAMPLE_W-1:0] trough_base_l;
    logic signed [SAMPLE_W-1:0] trough_base_r;
    logic signed [SAMPLE_W-1:0] mean_l;
    logic signed [SAMPLE_W-1:0] mean_r;
    logic signed [SAMPLE_W-1:0] n_peak_l;
    logic signed [SAMPLE_W-1:0] n_peak_r;
    logic signed [SAMPLE_W-1:0] n_trough_l;
    logic signed [SAMPLE_W-1:0] n_trough_r;
    logic [ACC_W-1:0]      quo_l_signed;
    logic [ACC_W-1:0]      quo_r_signed;

    // Decimation phase: a zero step counts as one, and a phase at or past the step wraps.
    always_comb begin
        step_eff  = (r_step_cfg == '0) ? STEP_W'(1) : r_step_cfg;
        phase_a   = (r_phase >= step_eff) ? '0 : r_phase;
        take      = (phase_a == '0) && (r_count < CNT_W'(MAX_CHUNK_FRAMES));
        phase_inc = {1'b0, phase_a} + (STEP_W+1)'(1);
        n_phase   = (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[STEP_W-1:0];
    end

    // Sample normalization and accumulation.
    always_comb begin
        smp_l   = (r_sample_format == FMT_S16) ? $signed(i_left_raw)  : f_norm8(i_left_raw[7:0]);
        smp_r   = (r_sample_format == FMT_S16) ? $signed(i_right_raw) : f_norm8(i_right_raw[7:0]);
        n_acc_l = take ? (r_acc_l + ACC_W'(smp_l)) : r_acc_l;
        n_acc_r = take ? (r_acc_r + ACC_W'(smp_r)) : r_acc_r;
        n_count = take ? (r_count + CNT_W'(1)) : r_count;
    end

    // Means from the divider, and the extremes they move.
    always_comb begin
        peak_base_l   = r_peak_l;
        peak_base_r   = r_peak_r;
        trough_base_l = r_trough_l;
        trough_base_r = r_trough_r;
        quo_l_signed  = r_neg_l ? (~r_lane_l.quo + ACC_W'(1)) : r_lane_l.quo;
        quo_r_signed  = r_neg_r ? (~r_lane_r.quo + ACC_W'(1)) : r_lane_r.quo;
        mean_l        = (r_den == '0) ? '0 : $signed(quo_l_signed[SAMPLE_W-1:0]);
        mean_r        = (r_den == '0) ? '0 : $signed(quo_r_signed[SAMPLE_W-1:0]);
        n_peak_l      = (mean_l > peak_base_l)   ? mean_l : peak_base_l;
        n_peak_r      = (mean_r > peak_base_r)   ? mean_r : peak_base_r;
        n_trough_l    = (mean_l < trough_base_l) ? mean_l : trough_base_l;
        n_trough_r    = (mean_r < trough_base_r) ? mean_r : trough_base_r;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= FMT_S16;
            r_step_cfg      <= STEP_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[0];
                REG_STEP_SIZE:     r_step_cfg      <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Chunk accumulation; a closing item clears the chunk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_acc_l <= '0;
            r_acc_r <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_cmd.chunk_close) begin
                r_phase <= '0;
                r_acc_l <= '0;
                r_acc_r <= '0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_acc_l <= n_acc_l;
                r_acc_r <= n_acc_r;
                r_count <= n_count;
            end
        end
    end

    // Running extremes: a new file resets them, a finished mean updates them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_l   <= PEAK_RESET;
            r_peak_r   <= PEAK_RESET;
            r_trough_l <= TROUGH_RESET;
            r_trough_r <= TROUGH_RESET;
        end else if (i_cmd.accept && i_new_file) begin
            r_peak_l   <= PEAK_RESET;
            r_peak_r   <= PEAK_RESET;
            r_trough_l <= TROUGH_RESET;
            r_trough_r <= TROUGH_RESET;
        end else if (i_cmd.load_out) begin
            r_peak_l   <= n_peak_l;
            r_peak_r   <= n_peak_r;
            r_trough_l <= n_trough_l;
            r_trough_r <= n_trough_r;
        end
    end

    // Serial divider: loaded with the sum magnitudes on a closing item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.chunk_close) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chunk_close) begin
            r_neg_l      <= n_acc_l[ACC_W-1];
            r_neg_r      <= n_acc_r[ACC_W-1];
            r_lane_l.rem <= '0;
            r_lane_r.rem <= '0;
            r_lane_l.quo <= n_acc_l[ACC_W-1] ? ACC_W'(-n_acc_l) : n_acc_l;
            r_lane_r.quo <= n_acc_r[ACC_W-1] ? ACC_W'(-n_acc_r) : n_acc_r;
            r_den        <= n_count;
        end else if (i_cmd.div_step) begin
            r_lane_l <= f_div_step(r_lane_l, r_den);
            r_lane_r <= f_div_step(r_lane_r, r_den);
        end
    end

    // Output register, written only when the slot is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_mean_l <= mean_l;
            r_out_mean_r <= mean_r;
            r_out_max_l  <= n_peak_l;
            r_out_max_r  <= n_peak_r;
            r_out_min_l  <= n_trough_l;
            r_out_min_r  <= n_trough_r;
            r_out_frames <= r_den;
        end
    end

    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_mean_left    = r_out_mean_l;
    assign o_mean_right   = r_out_mean_r;
    assign o_max_left     = r_out_max_l;
    assign o_max_right    = r_out_max_r;
    assign o_min_left     = r_out_min_l;
    assign o_min_right    = r_out_min_r;
    assign o_frames_used  = r_out_frames;

endmodule

/* sv/stereo_waveform_envelope.sv */
// Stereo waveform envelope: one stereo PCM frame per item, normalized to Q1.15,
// decimated by the programmed step and averaged per chunk. A frame without chunk_end
// leaves the block ready for the next frame. A chunk_end frame starts a two-lane
// serial divider that retires one quotient bit per cycle over the 33-bit sums, so
// the block stalls its input from that frame until the result is loaded into the
// output register, and longer while a previous result still waits there. The result
// item then sits in the output register while the next frames are taken. The
// minimum and maximum means run across chunks until a frame carries new_file.
// Uses swe_pkg, swe_ctrl and swe_dp.
module stereo_waveform_envelope (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_left_raw,
    input  logic [15:0]                         i_right_raw,
    input  logic                                i_chunk_end,
    input  logic                                i_new_file,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [15:0]                  o_mean_left,
    output logic signed [15:0]                  o_mean_right,
    output logic signed [15:0]                  o_max_left,
    output logic signed [15:0]                  o_max_right,
    output logic signed [15:0]                  o_min_left,
    output logic signed [15:0]                  o_min_right,
    output logic [swe_pkg::CNT_W-1:0]           o_frames_used
);
    import swe_pkg::*;

    t_swe_cmd cmd;
    t_swe_sts sts;

    // Sequencing and handshakes.
    swe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_chunk_end (i_chunk_end),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    swe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_left_raw    (i_left_raw),
        .i_right_raw   (i_right_raw),
        .i_new_file    (i_new_file),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_mean_left   (o_mean_left),
        .o_mean_right  (o_mean_right),
        .o_max_left    (o_max_left),
        .o_max_right   (o_max_right),
        .o_min_left    (o_min_left),
        .o_min_right   (o_min_right),
        .o_frames_used (o_frames_used)
    );

endmodule

/* sv/swe_checker.sv */
// Port-level checks for the stereo waveform envelope block, bound to the top level.
// Depends on swe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swe_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                i_chunk_end,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [15:0]                  o_mean_left,
    input  logic signed [15:0]                  o_mean_right,
    input  logic signed [15:0]                  o_max_left,
    input  logic signed [15:0]                  o_max_right,
    input  logic signed [15:0]                  o_min_left,
    input  logic signed [15:0]                  o_min_right,
    input  logic [swe_pkg::CNT_W-1:0]           o_frames_used
);
    import swe_pkg::*;

    logic in_take;
    logic out_hold;
    logic in_order_l;
    logic in_order_r;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_hold   = o_out_valid && i_out_stall;
    assign in_order_l = (o_min_left <= o_mean_left) && (o_mean_left <= o_max_left);
    assign in_order_r = (o_min_right <= o_mean_right) && (o_mean_right <= o_max_right);

    // A held result item keeps its valid, its left mean and its frame count.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_mean_left) && $stable(o_frames_used), "stalled result changed")

    // A taken chunk-end item leaves the input stalled after it.
    `CHK_NEXT(a_busy_after_end, i_clk, i_rst_n, in_take && i_chunk_end, o_in_stall, "input ready right after chunk end")

    // A new result item only appears at the end of a busy stretch.
    `CHK_IMPLY(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without a chunk end")

    // Every chunk sums at least its first frame.
    `CHK_IMPLY(a_frames_nonzero, i_clk, i_rst_n, o_out_valid, o_frames_used != '0, "empty chunk reported")

    // The extremes always bracket the mean they were updated with.
    `CHK_IMPLY(a_extremes_bracket, i_clk, i_rst_n, o_out_valid, in_order_l && in_order_r, "mean outside running extremes")

endmodule

bind stereo_waveform_envelope swe_checker u_swe_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the stereo waveform envelope block.
// Depends on swe_pkg and stereo_waveform_envelope; a scoreboard class predicts each chunk summary.
module testbench;
    import swe_pkg::*;

    localparam int LIMIT         = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;

    // One result item: the chunk means, the running extremes and the frame count.
    typedef struct packed {
        logic signed [15:0] mean_l;
        logic signed [15:0] mean_r;
        logic signed [15:0] max_l;
        logic signed [15:0] max_r;
        logic signed [15:0] min_l;
        logic signed [15:0] min_r;
        logic [CNT_W-1:0]   frames;
    } t_chunk_summary;

    // Tracks the chunk sums and extremes and holds the summaries still due.
    class t_envelope_tracker;
        logic                 fmt;
        logic [STEP_W-1:0]    step_reg;
        int unsigned          phase;
        longint               sum_l;
        longint               sum_r;
        int unsigned          taken;
        int                   peak_l;
        int                   peak_r;
        int                   trough_l;
        int                   trough_r;
        t_chunk_summary       due_summaries[$];
        int                   mismatches;

        function new();
            fmt        = FMT_S16;
            step_reg   = 1;
            phase      = 0;
            sum_l      = 0;
            sum_r      = 0;
            taken      = 0;
            peak_l     = -32768;
            peak_r     = -32768;
            trough_l   = 32767;
            trough_r   = 32767;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SAMPLE_FORMAT) begin
                fmt = data[0];
            end else if (idx == REG_STEP_SIZE) begin
                step_reg = data;
            end
        endfunction

        // Raw sample bits to Q1.15; the 8-bit scaling truncates toward zero.
        function int to_q15(logic [15:0] raw);
            if (fmt == FMT_U8) begin
                return ((int'(raw[7:0]) - 128) * 32768) / 255;
            end
            return int'($signed(raw));
        endfunction

        function int pending();
            return due_summaries.size();
        endfunction

        // Called for every accepted input item.
        function void take_frame(logic [15:0] l, logic [15:0] r, logic ce, logic nf);
            int unsigned    eff_step;
            int             ml;
            int             mr;
            t_chunk_summary s;
            eff_step = (step_reg == 0) ? 1 : step_reg;
            if (nf) begin
                peak_l   = -32768;
                peak_r   = -32768;
                trough_l = 32767;
                trough_r = 32767;
            end
            // A step lowered mid-chunk wraps the phase at once.
            if (phase >= eff_step) phase = 0;
            if (phase == 0 && taken < MAX_CHUNK_FRAMES) begin
                sum_l += to_q15(l);
                sum_r += to_q15(r);
                taken++;
            end
            phase++;
            if (phase >= eff_step) phase = 0;
            if (!ce) return;

            ml = (taken == 0) ? 0 : int'(sum_l / longint'(taken));
            mr = (taken == 0) ? 0 : int'(sum_r / longint'(taken));
            if (ml > peak_l) peak_l = ml;
            if (mr > peak_r) peak_r = mr;
            if (ml < trough_l) trough_l = ml;
            if (mr < trough_r) trough_r = mr;

            s.mean_l = ml[15:0];
            s.mean_r = mr[15:0];
            s.max_l  = peak_l[15:0];
            s.max_r  = peak_r[15:0];
            s.min_l  = trough_l[15:0];
            s.min_r  = trough_r[15:0];
            s.frames = taken[CNT_W-1:0];
            due_summaries = {due_summaries, s};

            phase = 0;
            sum_l = 0;
            sum_r = 0;
            taken = 0;
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Called for every accepted result item.
        function void check_summary(t_chunk_summary got);
            t_chunk_summary want;
            if (due_summaries.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = due_summaries.pop_front();
            compare_field("mean_left", want.mean_l, got.mean_l);
            compare_field("mean_right", want.mean_r, got.mean_r);
            compare_field("max_left", want.max_l, got.max_l);
            compare_field("max_right", want.max_r, got.max_r);
            compare_field("min_left", want.min_l, got.min_l);
            compare_field("min_right", want.min_r, got.min_r);
            compare_field("frames_used", want.frames, got.frames);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_SAMPLE_FORMAT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [15:0]            i_left_raw = '0;
    logic [15:0]            i_right_raw = '0;
    logic                   i_chunk_end = 1'b0;
    logic                   i_new_file = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [15:0]     o_mean_left;
    logic signed [15:0]     o_mean_right;
    logic signed [15:0]     o_max_left;
    logic signed [15:0]     o_max_right;
    logic signed [15:0]     o_min_left;
    logic signed [15:0]     o_min_right;
    logic [CNT_W-1:0]       o_frames_used;

    t_envelope_tracker tracker = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    stereo_waveform_envelope DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_left_raw    (i_left_raw),
        .i_right_raw   (i_right_raw),
        .i_chunk_end   (i_chunk_end),
        .i_new_file    (i_new_file),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mean_left   (o_mean_left),
        .o_mean_right  (o_mean_right),
        .o_max_left    (o_max_left),
        .o_max_right   (o_max_right),
        .o_min_left    (o_min_left),
        .o_min_right   (o_min_right),
        .o_frames_used (o_frames_used)
    );

    always #5 i_clk = ~i_clk;

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each accepted result item, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_summary({o_mean_left, o_mean_right, o_max_left, o_max_right,
                                   o_min_left, o_min_right, o_frames_used});
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Present one frame, with optional idle cycles first, and wait until it is taken.
    task automatic send_frame(input logic [15:0] l, input logic [15:0] r,
                              input logic ce, input logic nf);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_left_raw  <= l;
        i_right_raw <= r;
        i_chunk_end <= ce;
        i_new_file  <= nf;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_frame(l, r, ce, nf);
    endtask

    // Stop sending, let every due result drain, then give the block time to go idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic fmt, input logic [STEP_W-1:0] step);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_SAMPLE_FORMAT;
        i_cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, fmt};
        @(posedge i_clk);
        tracker.write_reg(REG_SAMPLE_FORMAT, {{(CFG_DATA_W-1){1'b0}}, fmt});
        i_cfg_index <= REG_STEP_SIZE;
        i_cfg_data  <= step;
        @(posedge i_clk);
        tracker.write_reg(REG_STEP_SIZE, step);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly random bits, sometimes one of the full-scale or midpoint codes.
    function automatic logic [15:0] random_sample();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0080;
            5:       return 16'h007F;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {STEP_W{1'b1}};
            2:       return STEP_W'($urandom_range(1, 65535));
            default: return STEP_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Well-formed chunks with random content: mostly short, now and then longer.
    task automatic run_chunks(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                send_frame(random_sample(), random_sample(), k == len - 1,
                           $urandom_range(7) == 0);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a full-scale chunk whose means equal the reset extremes.
        send_frame(16'h7FFF, 16'h8000, 1'b1, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0);
        // New file together with chunk end.
        send_frame(16'h0001, 16'hFFFF, 1'b1, 1'b1);
        // Odd sums that truncate toward zero.
        send_frame(16'h1234, 16'hABCD, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0);

        // 8-bit samples; the upper byte must be ignored.
        settle();
        write_cfg(FMT_U8, 16'd1);
        send_frame(16'h00FF, 16'hFF00, 1'b0, 1'b0);
        send_frame(16'h0080, 16'h007F, 1'b1, 1'b0);
        send_frame(16'hAB80, 16'h5501, 1'b1, 1'b1);

        // A step of zero behaves as a step of one.
        settle();
        write_cfg(FMT_U8, 16'd0);
        send_frame(16'h0010, 16'h00F0, 1'b0, 1'b0);
        send_frame(16'h0020, 16'h00E0, 1'b0, 1'b0);
        send_frame(16'h0030, 16'h00D0, 1'b1, 1'b0);

        // Largest step: only the first frame of the chunk is taken.
        settle();
        write_cfg(FMT_S16, 16'hFFFF);
        send_frame(16'h4000, 16'hC000, 1'b0, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0);

        // Step lowered mid-chunk while the phase is already past the new step.
        settle();
        write_cfg(FMT_S16, 16'd4);
        send_frame(16'h0100, 16'hFF00, 1'b0, 1'b0);
        send_frame(16'h0200, 16'hFE00, 1'b0, 1'b0);
        send_frame(16'h0300, 16'hFD00, 1'b0, 1'b0);
        settle();
        write_cfg(FMT_S16, 16'd2);
        send_frame(16'h0400, 16'hFC00, 1'b0, 1'b0);
        send_frame(16'h0500, 16'hFB00, 1'b0, 1'b0);
        send_frame(16'h0600, 16'hFA00, 1'b1, 1'b0);

        // Random part: four idling mixes, two settings each.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            for (int c = 0; c < 2; c++) begin
                settle();
                write_cfg(1'($urandom_range(1)), random_step());
                run_chunks(180);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
